FILE: src/psqf_pkg.sv
// types and constants shared by the packed symmetric quadratic form core
// no dependencies; imported by psqf_datapath and the top level
package psqf_pkg;

   localparam int ElemW   = 16;  // Q8.8 vector and matrix elements
   localparam int ProdW   = 32;  // x_i * x_j, Q16.16
   localparam int TermW   = 49;  // a * x_i * x_j doubled, Q25.24
   localparam int AccW    = 64;  // Q40.24 accumulator
   localparam int SizeW   = 7;   // matrix_size register

   localparam logic MODE_VECTOR = 1'b0;
   localparam logic MODE_MATRIX = 1'b1;

   // control that travels with one matrix element down the datapath
   typedef struct packed {
      logic valid;
      logic contrib;    // element lies inside the triangle
      logic offdiag;    // term counts twice
      logic last;       // closes the pass
      logic count_err;  // element count disagrees with n(n+1)/2
   } op_type;

endpackage

FILE: src/psqf_datapath.sv
// multiply pipeline and saturating accumulator of the quadratic form core
// depends on psqf_pkg
module psqf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  psqf_pkg::op_type                    op_in,
   input  logic signed [psqf_pkg::ElemW-1:0]   value_in,
   input  logic signed [psqf_pkg::ElemW-1:0]   xi_in,
   input  logic signed [psqf_pkg::ElemW-1:0]   xj_in,
   output logic                                busy,
   output logic                                rsp_valid,
   output logic signed [psqf_pkg::AccW-1:0]    rsp_quad_value,
   output logic                                rsp_overflow,
   output logic                                rsp_count_error
);
   import psqf_pkg::*;

   localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
   localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

   op_type                  op1_ff, op2_ff;
   logic signed [ElemW-1:0] val1_ff;
   logic signed [ProdW-1:0] prod1_ff, prod1_in;
   logic signed [TermW-1:0] term2_ff, term2_in;
   logic signed [2*ElemW+ProdW-ElemW-1:0] term_raw;
   logic signed [AccW-1:0]  acc_ff, acc_sat;
   logic                    sticky_ff, ovf_now;
   logic signed [AccW:0]    sum;
   logic                    rsp_valid_ff;
   logic signed [AccW-1:0]  quad_ff;
   logic                    ovf_out_ff, cnt_err_ff;

   // stage 1: x_i * x_j
   assign prod1_in = xi_in * xj_in;

   // stage 2: a * (x_i * x_j), doubled off the diagonal, zero outside the triangle
   always_comb begin
      term_raw = val1_ff * prod1_ff;
      priority if (!op1_ff.contrib) begin
         term2_in = '0;
      end else if (op1_ff.offdiag) begin
         term2_in = TermW'(term_raw) <<< 1;
      end else begin
         term2_in = TermW'(term_raw);
      end
   end

   // stage 3: saturating accumulate
   always_comb begin
      sum     = {acc_ff[AccW-1], acc_ff} + (AccW+1)'(term2_ff);
      ovf_now = sum[AccW] ^ sum[AccW-1];
      if (ovf_now) begin
         acc_sat = sum[AccW] ? AccMin : AccMax;
      end else begin
         acc_sat = sum[AccW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
      val1_ff  <= value_in;
      term2_ff <= term2_in;
      if (reset) begin
         op1_ff       <= '0;
         op2_ff       <= '0;
         acc_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op1_ff       <= op_in;
         op2_ff       <= op1_ff;
         rsp_valid_ff <= 1'b0;
         if (op2_ff.valid) begin
            if (op2_ff.last) begin
               acc_ff       <= '0;
               sticky_ff    <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end else begin
               acc_ff    <= acc_sat;
               sticky_ff <= sticky_ff | ovf_now;
            end
         end
      end
   end

   // result payload, only meaningful under the strobe
   always_ff @(posedge clock) begin
      if (op2_ff.valid && op2_ff.last) begin
         quad_ff    <= acc_sat;
         ovf_out_ff <= sticky_ff | ovf_now;
         cnt_err_ff <= op2_ff.count_err;
      end
   end

   assign busy            = op1_ff.valid | op2_ff.valid;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quad_value  = quad_ff;
   assign rsp_overflow    = ovf_out_ff;
   assign rsp_count_error = cnt_err_ff;

endmodule

FILE: src/packed_symmetric_quadratic_form_core.sv
// packed symmetric quadratic form core: x^T A x over a packed lower triangle
// holds the vector memory and the index counters; depends on psqf_pkg and
// psqf_datapath
//
// usage:
//   - set the dimension n through csr_write_enable / csr_write_data while idle
//     (0 is taken as 1, values above MAX_SIZE as MAX_SIZE)
//   - transfer the vector with req_mode = 0, one element per cycle while busy
//     is low, req_last on the final one
//   - then transfer the triangle row-major with req_mode = 1; req_last on the
//     final element closes the pass
//   - a transfer happens on a clock edge with start high and busy low
//   - each matrix element holds busy until it is through, so matrix elements
//     go in one at a time: memory read, x_i*x_j, a*product, accumulate
//   - the result strobe rsp_valid is registered behind op_ff, op1_ff and
//     op2_ff after the final transfer and lasts one cycle; there is no
//     backpressure, the receiver must take it
//   - reset clears the indices, accumulator and flags and sets n to 1; the
//     vector memory keeps its contents and needs no clearing pass, entries
//     must be written before the triangle uses them
module packed_symmetric_quadratic_form_core #(
   parameter int MAX_SIZE = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic signed [psqf_pkg::ElemW-1:0]   req_value,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic signed [psqf_pkg::AccW-1:0]    rsp_quad_value,
   output logic                                rsp_overflow,
   output logic                                rsp_count_error,
   input  logic                                csr_write_enable,
   input  logic [psqf_pkg::SizeW-1:0]          csr_write_data
);
   import psqf_pkg::*;

   localparam int AddrW  = $clog2(MAX_SIZE);
   localparam int IdxW   = $clog2(MAX_SIZE + 1);
   localparam int ExpMax = MAX_SIZE * (MAX_SIZE + 1) / 2;
   localparam int CntW   = $clog2(ExpMax + 2);
   localparam int NW     = 2 * IdxW + 1;
   localparam logic [IdxW-1:0] MaxIdx = IdxW'(MAX_SIZE);
   localparam logic [CntW-1:0] CntTop = '1;

   logic [SizeW-1:0]       size_ff;
   logic [IdxW-1:0]        wr_idx_ff, row_ff, col_ff;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [IdxW-1:0]        n_use;
   logic [NW-1:0]          exp_full;
   logic [CntW-1:0]        exp_cnt;
   logic                   accept, dp_busy, wr_en, contrib, offdiag;
   op_type                 op_ff;
   logic signed [ElemW-1:0] value_ff, xi_ff, xj_ff;
   logic [ElemW-1:0]       vmem [MAX_SIZE];

   assign accept = start && !busy;
   assign busy   = op_ff.valid | dp_busy;

   // dimension in use, clamped
   always_comb begin
      priority if (size_ff == '0) begin
         n_use = IdxW'(1);
      end else if (32'(size_ff) > 32'(MAX_SIZE)) begin
         n_use = MaxIdx;
      end else begin
         n_use = IdxW'(size_ff);
      end
   end

   always_comb begin
      exp_full = (NW'(n_use) * (NW'(n_use) + NW'(1))) >> 1;
      exp_cnt  = CntW'(exp_full);
      cnt_in   = (cnt_ff == CntTop) ? cnt_ff : cnt_ff + CntW'(1);
      contrib  = row_ff < n_use;
      offdiag  = col_ff < row_ff;
      wr_en    = accept && (req_mode == MODE_VECTOR) && (wr_idx_ff < MaxIdx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SizeW'(1);
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   // index counters and element count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         cnt_ff    <= '0;
         op_ff     <= '0;
      end else begin
         op_ff <= '0;
         if (accept && req_mode == MODE_VECTOR) begin
            if (req_last) begin
               wr_idx_ff <= '0;
            end else if (wr_idx_ff < MaxIdx) begin
               wr_idx_ff <= wr_idx_ff + IdxW'(1);
            end
         end
         if (accept && req_mode == MODE_MATRIX) begin
            op_ff.valid     <= 1'b1;
            op_ff.contrib   <= contrib;
            op_ff.offdiag   <= offdiag;
            op_ff.last      <= req_last;
            op_ff.count_err <= cnt_in != exp_cnt;
            if (req_last) begin
               row_ff <= '0;
               col_ff <= '0;
               cnt_ff <= '0;
            end else begin
               cnt_ff <= cnt_in;
               if (contrib) begin
                  if (offdiag) begin
                     col_ff <= col_ff + IdxW'(1);
                  end else begin
                     col_ff <= '0;
                     row_ff <= row_ff + IdxW'(1);
                  end
               end
            end
         end
      end
   end

   // vector memory: one write port, two registered read ports; busy keeps a
   // write from meeting a read in flight
   always_ff @(posedge clock) begin
      if (wr_en) begin
         vmem[wr_idx_ff[AddrW-1:0]] <= req_value;
      end
      if (accept && req_mode == MODE_MATRIX && contrib) begin
         xi_ff <= vmem[row_ff[AddrW-1:0]];
         xj_ff <= vmem[col_ff[AddrW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= req_value;
      end
   end

   psqf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .op_in           (op_ff),
      .value_in        (value_ff),
      .xi_in           (xi_ff),
      .xj_in           (xj_ff),
      .busy            (dp_busy),
      .rsp_valid       (rsp_valid),
      .rsp_quad_value  (rsp_quad_value),
      .rsp_overflow    (rsp_overflow),
      .rsp_count_error (rsp_count_error)
   );

   // a result follows only a final matrix transfer, through the op registers
   a_rsp_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && req_mode == MODE_MATRIX && req_last, 4))
      else $error("result without a closing matrix transfer");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_wr_idx_range: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= MaxIdx)
      else $error("vector write index past the memory");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_ff <= row_ff)
      else $error("column index beyond the diagonal");

   a_no_rsp_while_fed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_MATRIX) |=> !rsp_valid)
      else $error("result overlaps a pass still in flight");

endmodule
